### design/tcg_pkg.sv
// Package for the text cell glyph renderer.
// Glyph geometry, derived widths, item codes and the job record passed
// from the front end to the back end. No dependencies.
package tcg_pkg;

	// Glyph geometry
	localparam int GLYPH_W     = 8;
	localparam int GLYPH_H     = 8;
	localparam int CELL_PIXELS = GLYPH_W * GLYPH_H;
	localparam int STORE_DEPTH = 256 * CELL_PIXELS;
	localparam int ST_AW       = $clog2(STORE_DEPTH);

	// Counter widths inside a glyph
	localparam int U_W = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
	localparam int V_W = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;

	// Framebuffer line length and pixel row widths
	localparam int LINE_W = 8 + $clog2(GLYPH_W);
	localparam int PROW_W = 8 + $clog2(GLYPH_H);

	// Field widths
	localparam int PIXA_W  = 22;
	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;

	// Item modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// One classified item
	typedef struct packed {
		logic                render;
		logic [ST_AW-1:0]    waddr;
		logic [7:0]          coverage;
		logic [7:0]          symbol;
		logic [PIXA_W-1:0]   base;
		logic [LINE_W-1:0]   line;
		logic [COLOR_W-1:0]  fore;
		logic [COLOR_W-1:0]  back;
	} tcg_job_t;

endpackage

### design/tcg_ifs.sv
// Channel interfaces of the text cell glyph renderer: input items,
// output pixels and the columns register write channel.
// Depends on tcg_pkg.
interface tcg_item_if;
	import tcg_pkg::*;

	logic               valid;
	logic               ready;
	logic               mode;
	logic [7:0]         symbol;
	logic [2:0]         glyph_col;
	logic [2:0]         glyph_row;
	logic [7:0]         coverage;
	logic [7:0]         cell_col;
	logic [7:0]         cell_row;
	logic [COLOR_W-1:0] fore_color;
	logic [COLOR_W-1:0] back_color;

	modport source (
		output valid, mode, symbol, glyph_col, glyph_row, coverage,
		       cell_col, cell_row, fore_color, back_color,
		input  ready
	);
	modport sink (
		input  valid, mode, symbol, glyph_col, glyph_row, coverage,
		       cell_col, cell_row, fore_color, back_color,
		output ready
	);
endinterface

interface tcg_pixel_if;
	import tcg_pkg::*;

	logic              valid;
	logic              ready;
	logic [PIXA_W-1:0] pixel_address;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              last;

	modport source (
		output valid, pixel_address, red, green, blue, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_address, red, green, blue, last,
		output ready
	);
endinterface

interface tcg_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### design/tcg_front.sv
// Front end: accepts input items, drops out-of-glyph loads, and works out
// the store write address or the cell's base framebuffer address.
// Depends on tcg_pkg and tcg_ifs.
module tcg_front (
	input  logic                clk,
	input  logic                arst_n,
	tcg_item_if.sink            item_in,
	input  logic [7:0]          columns,
	output tcg_pkg::tcg_job_t   job,
	output logic                job_valid,
	input  logic                job_ready
);
	import tcg_pkg::*;

	logic              vld_s1;
	tcg_job_t          job_s1;
	tcg_job_t          job_d;
	logic              keep;
	logic              accept;
	logic [LINE_W-1:0] line;
	logic [PROW_W-1:0] pix_y;
	logic [PIXA_W-1:0] row_off;

	assign item_in.ready = !vld_s1 || job_ready;
	assign accept        = item_in.valid && item_in.ready;

	// Classify and precompute
	always_comb begin
		line    = LINE_W'(columns) * LINE_W'(GLYPH_W);
		pix_y   = PROW_W'(item_in.cell_row) * PROW_W'(GLYPH_H);
		row_off = PIXA_W'(pix_y) * PIXA_W'(line);
		keep    = (item_in.mode == MODE_RENDER) ||
		          (({1'b0, item_in.glyph_col} < 4'(GLYPH_W)) &&
		           ({1'b0, item_in.glyph_row} < 4'(GLYPH_H)));
		job_d.render   = (item_in.mode == MODE_RENDER);
		job_d.waddr    = ST_AW'(item_in.symbol) * ST_AW'(CELL_PIXELS)
		               + ST_AW'(item_in.glyph_row) * ST_AW'(GLYPH_W)
		               + ST_AW'(item_in.glyph_col);
		job_d.coverage = item_in.coverage;
		job_d.symbol   = item_in.symbol;
		job_d.base     = row_off + PIXA_W'(item_in.cell_col) * PIXA_W'(GLYPH_W);
		job_d.line     = line;
		job_d.fore     = item_in.fore_color;
		job_d.back     = item_in.back_color;
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (job_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end
	end

	assign job       = job_s1;
	assign job_valid = vld_s1;

endmodule

### design/tcg_queue.sv
// Short job queue between front and back ends.
// Depends on tcg_pkg.
module tcg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tcg_pkg::tcg_job_t   push_job,
	input  logic                push_valid,
	output logic                push_ready,
	output tcg_pkg::tcg_job_t   pop_job,
	output logic                pop_valid,
	input  logic                pop_ready
);
	import tcg_pkg::*;

	tcg_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = slot_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

endmodule

### design/tcg_back.sv
// Back end: owns the glyph store, performs coverage writes and walks each
// cell pixel by pixel through read, multiply and blend stages.
// Depends on tcg_pkg and tcg_ifs.
module tcg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tcg_pkg::tcg_job_t   job,
	input  logic                job_valid,
	output logic                job_ready,
	tcg_pixel_if.source         pixel_out
);
	import tcg_pkg::*;

	// Glyph store
	logic [7:0] store_mem [STORE_DEPTH];

	// Sequencer state
	logic               busy_q;
	logic [U_W-1:0]     u_q;
	logic [V_W-1:0]     v_q;
	logic [PIXA_W-1:0]  row_q;
	logic [7:0]         sym_q;
	logic [LINE_W-1:0]  line_q;
	logic [COLOR_W-1:0] fore_q;
	logic [COLOR_W-1:0] back_q;

	// Issue-side signals
	logic               en;
	logic               start;
	logic               do_pix;
	logic               st_we;
	logic [U_W-1:0]     cur_u;
	logic [V_W-1:0]     cur_v;
	logic [PIXA_W-1:0]  cur_row;
	logic [7:0]         cur_sym;
	logic [LINE_W-1:0]  cur_line;
	logic [COLOR_W-1:0] cur_fore;
	logic [COLOR_W-1:0] cur_back;
	logic               u_end;
	logic               pix_last;
	logic [ST_AW-1:0]   rd_addr;

	// Read stage
	logic               valid_s1;
	logic [7:0]         cov_s1;
	logic [PIXA_W-1:0]  addr_s1;
	logic               last_s1;
	logic [COLOR_W-1:0] fore_s1;
	logic [COLOR_W-1:0] back_s1;

	// Multiply stage, one lane per channel (blue, green, red)
	logic               valid_s2;
	logic [PIXA_W-1:0]  addr_s2;
	logic               last_s2;
	logic [15:0]        mag_s2  [3];
	logic               neg_s2  [3];
	logic [7:0]         base_s2 [3];

	// Output register
	logic               out_valid_q;
	logic [PIXA_W-1:0]  out_addr_q;
	logic               out_last_q;
	logic [7:0]         out_chan_q [3];

	logic [7:0]  f_ch [3];
	logic [7:0]  b_ch [3];
	logic [7:0]  diff [3];
	logic        neg  [3];
	logic [16:0] qsum [3];
	logic [7:0]  quot [3];
	logic [7:0]  chan [3];

	// Whole back pipeline moves when the output register can take a pixel
	assign en        = !out_valid_q || pixel_out.ready;
	assign start     = !busy_q && job_valid && en;
	assign job_ready = !busy_q && en;
	assign do_pix    = en && (busy_q || (start && job.render));
	assign st_we     = start && !job.render;

	// Current pixel: from the live cell, or the head job on its first pixel
	always_comb begin
		cur_u    = busy_q ? u_q    : '0;
		cur_v    = busy_q ? v_q    : '0;
		cur_row  = busy_q ? row_q  : job.base;
		cur_sym  = busy_q ? sym_q  : job.symbol;
		cur_line = busy_q ? line_q : job.line;
		cur_fore = busy_q ? fore_q : job.fore;
		cur_back = busy_q ? back_q : job.back;
		u_end    = (cur_u == U_W'(GLYPH_W - 1));
		pix_last = u_end && (cur_v == V_W'(GLYPH_H - 1));
		rd_addr  = ST_AW'(cur_sym) * ST_AW'(CELL_PIXELS)
		         + ST_AW'(cur_v) * ST_AW'(GLYPH_W) + ST_AW'(cur_u);
	end

	// Pixel walk, row by row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			u_q    <= '0;
			v_q    <= '0;
		end else if (do_pix) begin
			busy_q <= !pix_last;
			if (u_end) begin
				u_q <= '0;
				v_q <= pix_last ? '0 : cur_v + 1'b1;
			end else begin
				u_q <= cur_u + 1'b1;
				v_q <= cur_v;
			end
		end
	end

	// Cell context
	always_ff @(posedge clk) begin
		if (do_pix) begin
			row_q  <= u_end ? cur_row + PIXA_W'(cur_line) : cur_row;
			sym_q  <= cur_sym;
			line_q <= cur_line;
			fore_q <= cur_fore;
			back_q <= cur_back;
		end
	end

	// Store write port
	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[job.waddr] <= job.coverage;
		end
	end

	// Store read port, held while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			cov_s1 <= store_mem[rd_addr];
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= do_pix;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1 <= cur_row + PIXA_W'(cur_u);
			last_s1 <= pix_last;
			fore_s1 <= cur_fore;
			back_s1 <= cur_back;
		end
	end

	// |fore - back| and its sign per channel
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			f_ch[i] = fore_s1[i*8 +: 8];
			b_ch[i] = back_s1[i*8 +: 8];
			neg[i]  = (f_ch[i] < b_ch[i]);
			diff[i] = neg[i] ? b_ch[i] - f_ch[i] : f_ch[i] - b_ch[i];
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (en) begin
			addr_s2 <= addr_s1;
			last_s2 <= last_s1;
			for (int i = 0; i < 3; i++) begin
				mag_s2[i]  <= 16'(diff[i]) * 16'(cov_s1);
				neg_s2[i]  <= neg[i];
				base_s2[i] <= b_ch[i];
			end
		end
	end

	// Divide by 255 (exact for products up to 255*255), then offset from back
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qsum[i] = 17'(mag_s2[i]) + 17'(mag_s2[i][15:8]) + 17'd1;
			quot[i] = qsum[i][15:8];
			chan[i] = neg_s2[i] ? base_s2[i] - quot[i] : base_s2[i] + quot[i];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_addr_q <= addr_s2;
			out_last_q <= last_s2;
			for (int i = 0; i < 3; i++) begin
				out_chan_q[i] <= chan[i];
			end
		end
	end

	assign pixel_out.valid         = out_valid_q;
	assign pixel_out.pixel_address = out_addr_q;
	assign pixel_out.red           = out_chan_q[2];
	assign pixel_out.green         = out_chan_q[1];
	assign pixel_out.blue          = out_chan_q[0];
	assign pixel_out.last          = out_last_q;

endmodule

### design/text_cell_glyph_renderer_core.sv
// Text cell glyph renderer, top level: columns register, front end,
// job queue and back end.
// Depends on tcg_pkg, tcg_ifs, tcg_front, tcg_queue and tcg_back.
//
// Usage:
//   item_in carries load items (mode 0: one coverage byte into the glyph
//   store) and render items (mode 1: one character cell). Loads with a
//   glyph position outside the glyph are dropped. Each render item yields
//   GLYPH_W*GLYPH_H pixels on pixel_out, row by row, with last set on the
//   final pixel of the cell.
//   cfg writes the columns register (reset value 80); it is always ready
//   and must only be written while the block is idle.
// Timing:
//   A render item occupies the back-end pixel sequencer for its whole cell,
//   one pixel per cycle while pixel_out is not stalled; a load item only
//   writes the glyph store. The first pixel passes the front stage, a
//   queue slot, the store read, multiply and output register. A two-entry
//   job queue lets the front keep accepting while a cell is being drawn.
// Reset and stall:
//   arst_n clears all control state; the glyph store is not cleared and
//   must be loaded before use. When pixel_out is stalled the back pipeline
//   holds, the queue fills, and then item_in drops ready.
module text_cell_glyph_renderer_core (
	input  logic         clk,
	input  logic         arst_n,
	tcg_cfg_if.sink      cfg,
	tcg_item_if.sink     item_in,
	tcg_pixel_if.source  pixel_out
);
	import tcg_pkg::*;

	logic [7:0] columns_q;
	tcg_job_t   front_job;
	logic       front_valid;
	logic       front_ready;
	tcg_job_t   back_job;
	logic       back_valid;
	logic       back_ready;

	// Columns register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= 8'd80;
		end else if (cfg.valid) begin
			columns_q <= cfg.data;
		end
	end

	tcg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.columns   (columns_q),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	tcg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	tcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.pixel_out (pixel_out)
	);

endmodule
